### hdl/lstm_pkg.sv
// lstm_pkg: shared types and constants for the lstm forward step block
`timescale 1ns / 1ps
package lstm_pkg;

  localparam int DW    = 16;
  localparam int ACC_W = 40;
  localparam int PROD_W = 2 * DW;
  localparam logic signed [DW-1:0] Q_ONE = 16'sd4096;

  typedef enum logic { OP_WEIGHT = 1'b0, OP_FEATURE = 1'b1 } op_t;

  typedef enum logic { ACT_SIG = 1'b0, ACT_TANH = 1'b1 } act_mode_t;

  typedef enum logic [1:0] {
    G_FORGET = 2'd0, G_IN = 2'd1, G_OUT = 2'd2, G_CELL = 2'd3
  } gate_t;

  typedef enum logic [1:0] { SUB_BIAS, SUB_X, SUB_H, SUB_C } sub_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GATE, S_GWAIT, S_CELL, S_CWAIT, S_HID, S_HWAIT, S_OUT, S_OWAIT, S_EMIT
  } state_t;

  // control that travels with each operand pair into the multiply-accumulate
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // sigmoid samples at steps of 0.5 from 0 to 8, Q4.12
  localparam logic [12:0] SIG_TABLE [17] = '{
    13'd2048, 13'd2550, 13'd2994, 13'd3349, 13'd3608, 13'd3785, 13'd3902, 13'd3976,
    13'd4022, 13'd4051, 13'd4069, 13'd4079, 13'd4086, 13'd4090, 13'd4092, 13'd4094,
    13'd4095
  };

endpackage

### hdl/lstm_mac.sv
// lstm_mac: registered multiplier followed by a wide accumulator
`timescale 1ns / 1ps
module lstm_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lstm_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [lstm_pkg::DW-1:0]     a_i,
  input  logic signed [lstm_pkg::DW-1:0]     b_i,
  output logic signed [lstm_pkg::ACC_W-1:0]  acc_o,
  output logic                               done_o
);
  import lstm_pkg::*;

  mac_ctl_t                  ctl1_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl_i;
      done_r <= ctl1_r.vld & ctl1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
    if (ctl1_r.vld) begin
      if (ctl1_r.first) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign acc_o  = acc_r;
  assign done_o = done_r;

endmodule

### hdl/lstm_post.sv
// lstm_post: rounding, saturation and table based sigmoid or tanh
`timescale 1ns / 1ps
module lstm_post (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               done_i,
  input  logic signed [lstm_pkg::ACC_W-1:0]  acc_i,
  input  lstm_pkg::act_mode_t                mode_i,
  output logic signed [lstm_pkg::DW-1:0]     pre_o,
  output logic signed [lstm_pkg::DW-1:0]     res_o,
  output logic                               vld_o
);
  import lstm_pkg::*;

  localparam int Q_W = ACC_W - 12;

  function automatic logic signed [DW-1:0] sat_q(input logic signed [Q_W-1:0] v);
    logic signed [DW-1:0] r;
    if (v > Q_W'(32767)) begin
      r = 16'sd32767;
    end else if (v < -Q_W'(32768)) begin
      r = -16'sd32768;
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  function automatic logic signed [DW-1:0] act_sig(input logic signed [DW-1:0] x);
    logic [DW:0]   mag;
    logic [14:0]   a;
    logic [3:0]    idx;
    logic [12:0]   lo;
    logic [12:0]   hi;
    logic [9:0]    d;
    logic [20:0]   p;
    logic [12:0]   s;
    mag = x[DW-1] ? (DW+1)'(-(DW+1)'(x)) : (DW+1)'(x);
    a   = (mag > (DW+1)'(32767)) ? 15'd32767 : mag[14:0];
    idx = a[14:11];
    lo  = SIG_TABLE[idx];
    hi  = SIG_TABLE[5'(idx) + 5'd1];
    d   = 10'(hi - lo);
    p   = 21'(d) * 21'(a[10:0]);
    s   = lo + 13'(p[20:11]);
    return x[DW-1] ? DW'(13'd4096 - s) : DW'(s);
  endfunction

  function automatic logic signed [DW-1:0] act_tanh(input logic signed [DW-1:0] x);
    logic signed [DW:0]   x2;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] s;
    x2 = (DW+1)'(x) <<< 1;
    if (x2 > (DW+1)'(32767)) begin
      xs = 16'sd32767;
    end else if (x2 < -(DW+1)'(32768)) begin
      xs = -16'sd32768;
    end else begin
      xs = DW'(x2);
    end
    s = act_sig(xs);
    return (s <<< 1) - 16'sd4096;
  endfunction

  logic signed [ACC_W-1:0] rnd;
  logic signed [DW-1:0]    pre_r;
  logic signed [DW-1:0]    res_r;
  act_mode_t               mode_r;
  logic                    pv_r;
  logic                    rv_r;

  assign rnd = acc_i + ACC_W'(2048);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      pv_r <= done_i;
      rv_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (done_i) begin
      pre_r  <= sat_q(Q_W'(rnd >>> 12));
      mode_r <= mode_i;
    end
    if (pv_r) begin
      res_r <= (mode_r == ACT_TANH) ? act_tanh(pre_r) : act_sig(pre_r);
    end
  end

  assign pre_o = pre_r;
  assign res_o = res_r;
  assign vld_o = rv_r;

endmodule

### hdl/lstm_forward_step.sv
// lstm_forward_step: top level, weight memory, state vectors and step sequencer
`timescale 1ns / 1ps
// step: a feature transaction with end of vector starts a step; output stalls
//   lengthen the step
// throughput: one multiply-accumulate term per cycle through the single shared
//   multiplier while a sum is issued; while idle, weight and plain feature
//   transactions are taken one per cycle
// reset: synchronous active low; clears sequencer, counters, peephole enable,
//   hidden and cell vectors; the weight memory is undefined until written
module lstm_forward_step #(
  parameter int N_FEAT = 8,
  parameter int N_HID  = 16,
  parameter int N_OUT  = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [4:0]                     in_matrix_select,
  input  logic [5:0]                     in_weight_row,
  input  logic [5:0]                     in_weight_col,
  input  logic signed [lstm_pkg::DW-1:0] in_weight_value,
  input  logic signed [lstm_pkg::DW-1:0] in_feature_value,
  input  logic                           in_end_of_vector,
  input  logic                           in_start_sequence,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [5:0]                     out_output_index,
  output logic signed [lstm_pkg::DW-1:0] out_output_value,
  output logic                           out_last
);
  import lstm_pkg::*;

  // one flat weight memory, stores laid out back to back
  localparam int IW_BASE = 0;
  localparam int HW_BASE = IW_BASE + 4 * N_FEAT * N_HID;
  localparam int PW_BASE = HW_BASE + 4 * N_HID * N_HID;
  localparam int GB_BASE = PW_BASE + 3 * N_HID * N_HID;
  localparam int OW_BASE = GB_BASE + 4 * N_HID;
  localparam int OB_BASE = OW_BASE + N_HID * N_OUT;
  localparam int MEM_D   = OB_BASE + N_OUT;
  localparam int AW      = $clog2(MEM_D);

  localparam int HIW  = (N_HID > 1) ? $clog2(N_HID) : 1;
  localparam int FIW  = (N_FEAT > 1) ? $clog2(N_FEAT) : 1;
  localparam int KMAX = (N_FEAT > N_HID) ? N_FEAT : N_HID;
  localparam int KW   = (KMAX > 1) ? $clog2(KMAX) : 1;
  localparam int JMAX = (N_OUT > N_HID) ? N_OUT : N_HID;
  localparam int JW   = (JMAX > 1) ? $clog2(JMAX) : 1;
  localparam int CW   = $clog2(N_FEAT + 1);

  // sequencer state
  state_t st_r, st_nxt;
  sub_t   sub_r, sub_nxt;
  logic [1:0]    g_r, g_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic          cur_r;
  logic          pe_r;

  // feature buffer and state vectors (two banks, old and new)
  logic signed [DW-1:0] fb_r [N_FEAT];
  logic [CW-1:0]        fcnt_r;
  logic [CW-1:0]        xcnt_r;
  logic signed [DW-1:0] hid_r [2][N_HID];
  logic signed [DW-1:0] cel_r [2][N_HID];
  logic signed [DW-1:0] gate_r [4];

  // weight memory
  logic signed [DW-1:0] wmem [MEM_D];
  logic signed [DW-1:0] mem_q_r;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic                 wen;

  // operand issue
  mac_ctl_t             iss_ctl, mac_ctl_r;
  logic signed [DW-1:0] iss_a, iss_b, opa_r, opb_r;
  logic                 iss_mem, use_mem_r;
  logic signed [DW-1:0] mac_b;
  logic signed [ACC_W-1:0] acc;
  logic                 mac_done;
  act_mode_t            post_mode;
  logic signed [DW-1:0] pre_v, res_v;
  logic                 res_vld;

  // output register
  logic                 ov_r;
  logic [JW-1:0]        oidx_r;
  logic signed [DW-1:0] oval_r;
  logic                 olast_r;

  logic                 in_acc;
  logic                 feat_acc;
  logic                 pe_g;
  logic [KW-1:0]        cidx;
  logic signed [DW-1:0] h_rd, c_rd;

  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign feat_acc = in_acc & (in_op == OP_FEATURE);
  assign pe_g     = pe_r & (g_r != G_CELL);

  // single read port into each state vector, on its current bank
  assign cidx = (st_r == S_CELL) ? KW'(j_r) : k_r;
  assign h_rd = hid_r[cur_r][k_r[HIW-1:0]];
  assign c_rd = cel_r[cur_r][cidx[HIW-1:0]];

  // weight write decode, out of range writes dropped
  always_comb begin
    wen   = 1'b0;
    waddr = '0;
    if (in_acc && in_op == OP_WEIGHT) begin
      case (in_matrix_select) inside
        [5'd0:5'd3]: begin
          wen   = (32'(in_weight_row) < N_FEAT) && (32'(in_weight_col) < N_HID);
          waddr = AW'(IW_BASE + (int'(in_matrix_select) * N_FEAT
                  + int'(in_weight_row)) * N_HID + int'(in_weight_col));
        end
        [5'd4:5'd7]: begin
          wen   = (32'(in_weight_row) < N_HID) && (32'(in_weight_col) < N_HID);
          waddr = AW'(HW_BASE + ((int'(in_matrix_select) - 4) * N_HID
                  + int'(in_weight_row)) * N_HID + int'(in_weight_col));
        end
        [5'd8:5'd10]: begin
          wen   = (32'(in_weight_row) < N_HID) && (32'(in_weight_col) < N_HID);
          waddr = AW'(PW_BASE + ((int'(in_matrix_select) - 8) * N_HID
                  + int'(in_weight_row)) * N_HID + int'(in_weight_col));
        end
        [5'd11:5'd14]: begin
          wen   = (in_weight_row == 6'd0) && (32'(in_weight_col) < N_HID);
          waddr = AW'(GB_BASE + (int'(in_matrix_select) - 11) * N_HID
                  + int'(in_weight_col));
        end
        5'd15: begin
          wen   = (32'(in_weight_row) < N_HID) && (32'(in_weight_col) < N_OUT);
          waddr = AW'(OW_BASE + int'(in_weight_row) * N_OUT + int'(in_weight_col));
        end
        5'd16: begin
          wen   = (in_weight_row == 6'd0) && (32'(in_weight_col) < N_OUT);
          waddr = AW'(OB_BASE + int'(in_weight_col));
        end
        default: begin
          wen = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      wmem[waddr] <= in_weight_value;
    end
    mem_q_r <= wmem[raddr];
  end

  // sequencer: next state and operand issue
  always_comb begin
    st_nxt  = st_r;
    sub_nxt = sub_r;
    g_nxt   = g_r;
    k_nxt   = k_r;
    j_nxt   = j_r;
    iss_ctl = '0;
    iss_a   = '0;
    iss_b   = '0;
    iss_mem = 1'b1;
    raddr   = '0;
    case (st_r)
      S_IDLE: begin
        if (feat_acc && in_end_of_vector) begin
          st_nxt  = S_GATE;
          sub_nxt = SUB_BIAS;
          g_nxt   = G_FORGET;
          k_nxt   = '0;
          j_nxt   = '0;
        end
      end
      S_GATE: begin
        iss_ctl.vld = 1'b1;
        case (sub_r)
          SUB_BIAS: begin
            iss_ctl.first = 1'b1;
            raddr   = AW'(GB_BASE + int'(g_r) * N_HID + int'(j_r));
            iss_a   = Q_ONE;
            sub_nxt = SUB_X;
            k_nxt   = '0;
          end
          SUB_X: begin
            raddr = AW'(IW_BASE + (int'(g_r) * N_FEAT + int'(k_r)) * N_HID
                    + int'(j_r));
            // elements not delivered this step count as zero
            iss_a = (32'(k_r) < 32'(xcnt_r)) ? fb_r[k_r[FIW-1:0]] : '0;
            if (k_r == KW'(N_FEAT - 1)) begin
              sub_nxt = SUB_H;
              k_nxt   = '0;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
          SUB_H: begin
            raddr = AW'(HW_BASE + (int'(g_r) * N_HID + int'(k_r)) * N_HID
                    + int'(j_r));
            iss_a = h_rd;
            if (k_r == KW'(N_HID - 1)) begin
              k_nxt = '0;
              if (pe_g) begin
                sub_nxt = SUB_C;
              end else begin
                iss_ctl.last = 1'b1;
                st_nxt       = S_GWAIT;
              end
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
          default: begin
            // peephole term against the previous cell vector
            raddr = AW'(PW_BASE + (int'(g_r) * N_HID + int'(k_r)) * N_HID
                    + int'(j_r));
            iss_a = c_rd;
            if (k_r == KW'(N_HID - 1)) begin
              k_nxt        = '0;
              iss_ctl.last = 1'b1;
              st_nxt       = S_GWAIT;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        endcase
      end
      S_GWAIT: begin
        if (res_vld) begin
          sub_nxt = SUB_BIAS;
          k_nxt   = '0;
          if (g_r == G_CELL) begin
            st_nxt = S_CELL;
          end else begin
            g_nxt  = g_r + 2'd1;
            st_nxt = S_GATE;
          end
        end
      end
      S_CELL: begin
        // c' = g*i + c*f
        iss_ctl.vld = 1'b1;
        iss_mem     = 1'b0;
        if (k_r == '0) begin
          iss_ctl.first = 1'b1;
          iss_a = gate_r[G_CELL];
          iss_b = gate_r[G_IN];
          k_nxt = KW'(1);
        end else begin
          iss_ctl.last = 1'b1;
          iss_a  = c_rd;
          iss_b  = gate_r[G_FORGET];
          k_nxt  = '0;
          st_nxt = S_CWAIT;
        end
      end
      S_CWAIT: begin
        if (res_vld) begin
          st_nxt = S_HID;
        end
      end
      S_HID: begin
        // h' = tanh(c') * o
        iss_ctl = '{vld: 1'b1, first: 1'b1, last: 1'b1};
        iss_mem = 1'b0;
        iss_a   = res_v;
        iss_b   = gate_r[G_OUT];
        st_nxt  = S_HWAIT;
      end
      S_HWAIT: begin
        if (res_vld) begin
          g_nxt   = G_FORGET;
          sub_nxt = SUB_BIAS;
          k_nxt   = '0;
          if (j_r == JW'(N_HID - 1)) begin
            j_nxt  = '0;
            st_nxt = S_OUT;
          end else begin
            j_nxt  = j_r + 1'b1;
            st_nxt = S_GATE;
          end
        end
      end
      S_OUT: begin
        iss_ctl.vld = 1'b1;
        if (sub_r == SUB_BIAS) begin
          iss_ctl.first = 1'b1;
          raddr   = AW'(OB_BASE + int'(j_r));
          iss_a   = Q_ONE;
          sub_nxt = SUB_H;
          k_nxt   = '0;
        end else begin
          raddr = AW'(OW_BASE + int'(k_r) * N_OUT + int'(j_r));
          iss_a = h_rd;
          if (k_r == KW'(N_HID - 1)) begin
            iss_ctl.last = 1'b1;
            k_nxt  = '0;
            st_nxt = S_OWAIT;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_OWAIT: begin
        if (res_vld) begin
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          sub_nxt = SUB_BIAS;
          if (j_r == JW'(N_OUT - 1)) begin
            j_nxt  = '0;
            st_nxt = S_IDLE;
          end else begin
            j_nxt  = j_r + 1'b1;
            st_nxt = S_OUT;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      sub_r <= SUB_BIAS;
      g_r   <= '0;
      k_r   <= '0;
      j_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      sub_r <= sub_nxt;
      g_r   <= g_nxt;
      k_r   <= k_nxt;
      j_r   <= j_nxt;
    end
  end

  // config, feature count and bank select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pe_r   <= 1'b0;
      fcnt_r <= '0;
      xcnt_r <= '0;
      cur_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        pe_r <= cfg_wdata;
      end
      if (feat_acc) begin
        if (in_end_of_vector) begin
          fcnt_r <= '0;
          xcnt_r <= (32'(fcnt_r) < N_FEAT) ? fcnt_r + 1'b1 : fcnt_r;
        end else if (32'(fcnt_r) < N_FEAT) begin
          fcnt_r <= fcnt_r + 1'b1;
        end
      end
      // new vectors become current once the last hidden element is written
      if (st_r == S_HWAIT && res_vld && j_r == JW'(N_HID - 1)) begin
        cur_r <= ~cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feat_acc && 32'(fcnt_r) < N_FEAT) begin
      fb_r[fcnt_r[FIW-1:0]] <= in_feature_value;
    end
  end

  // hidden and cell vectors: reset and start of sequence clear both banks
  always_ff @(posedge clk) begin
    if (!rst_n || (feat_acc && in_start_sequence)) begin
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < N_HID; i++) begin
          hid_r[b][i] <= '0;
          cel_r[b][i] <= '0;
        end
      end
    end else if (res_vld) begin
      if (st_r == S_CWAIT) begin
        cel_r[~cur_r][j_r[HIW-1:0]] <= pre_v;
      end
      if (st_r == S_HWAIT) begin
        hid_r[~cur_r][j_r[HIW-1:0]] <= pre_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_GWAIT && res_vld) begin
      gate_r[g_r] <= res_v;
    end
  end

  // operand register in step with the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_ctl_r <= '0;
    end else begin
      mac_ctl_r <= iss_ctl;
    end
  end

  always_ff @(posedge clk) begin
    opa_r     <= iss_a;
    opb_r     <= iss_b;
    use_mem_r <= iss_mem;
  end

  assign mac_b = use_mem_r ? mem_q_r : opb_r;

  lstm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (mac_ctl_r),
    .a_i    (opa_r),
    .b_i    (mac_b),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // candidate gate and new cell use tanh, the rest sigmoid
  assign post_mode = (st_r == S_CWAIT || (st_r == S_GWAIT && g_r == G_CELL)) ?
                     ACT_TANH : ACT_SIG;

  lstm_post u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .done_i (mac_done),
    .acc_i  (acc),
    .mode_i (post_mode),
    .pre_o  (pre_v),
    .res_o  (res_v),
    .vld_o  (res_vld)
  );

  // result register, held while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (st_r == S_OWAIT && res_vld) begin
      ov_r <= 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OWAIT && res_vld) begin
      oidx_r  <= j_r;
      oval_r  <= res_v;
      olast_r <= (j_r == JW'(N_OUT - 1));
    end
  end

  assign out_valid        = ov_r;
  assign out_output_index = 6'(oidx_r);
  assign out_output_value = oval_r;
  assign out_last         = olast_r;

  // no activation result may appear while the sequencer is idle
  assert property (@(posedge clk) disable iff (!rst_n) !(st_r == S_IDLE && res_vld))
    else $error("activation result while idle");

  // a vector end transaction starts the gate phase
  assert property (@(posedge clk) disable iff (!rst_n)
    feat_acc && in_end_of_vector |=> st_r == S_GATE && sub_r == SUB_BIAS)
    else $error("step did not start");

  // feature count never exceeds the buffer depth
  assert property (@(posedge clk) disable iff (!rst_n) 32'(fcnt_r) <= N_FEAT)
    else $error("feature count overflow");

  // result register only loads in the output wait state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == S_OWAIT)
    else $error("unexpected result transaction");

endmodule

### tb/tb_lstm_forward_step.sv
// tb_lstm_forward_step: self-checking testbench for the lstm forward step block
`timescale 1ns / 1ps
module tb_lstm_forward_step;
  import lstm_pkg::*;

  localparam int FDIM = 8;
  localparam int HDIM = 16;
  localparam int ODIM = 4;
  localparam int M_GATE_B = 11;
  localparam int M_OUT_W = 15;
  localparam int M_OUT_B = 16;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 3000;

  typedef struct {
    op_t                op;
    logic [4:0]         msel;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] wval;
    logic signed [15:0] fval;
    logic               eov;
    logic               sos;
    bit                 has_y;
    logic [3:0][15:0]   y;
  } lstm_txn_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [15:0] val;
    logic               last;
  } y_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic [4:0] in_matrix_select = '0;
  logic [5:0] in_weight_row = '0;
  logic [5:0] in_weight_col = '0;
  logic signed [15:0] in_weight_value = '0;
  logic signed [15:0] in_feature_value = '0;
  logic in_end_of_vector = 1'b0;
  logic in_start_sequence = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_output_index;
  logic signed [15:0] out_output_value;
  logic out_last;

  lstm_forward_step dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_matrix_select(in_matrix_select), .in_weight_row(in_weight_row),
    .in_weight_col(in_weight_col), .in_weight_value(in_weight_value),
    .in_feature_value(in_feature_value), .in_end_of_vector(in_end_of_vector),
    .in_start_sequence(in_start_sequence),
    .out_valid(out_valid), .out_stall(out_stall), .out_output_index(out_output_index),
    .out_output_value(out_output_value), .out_last(out_last)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the block: weight stores, recurrent state, feature buffer
  // ---------------------------------------------------------------------------
  int  w_x [4*FDIM*HDIM];
  int  w_h [4*HDIM*HDIM];
  int  w_peep [3*HDIM*HDIM];
  int  b_gate [4*HDIM];
  int  w_y [HDIM*ODIM];
  int  b_y [ODIM];
  int  h_vec [HDIM];
  int  c_vec [HDIM];
  int  x_buf [FDIM];
  int  x_cnt;
  bit  peep_on;
  int  sig_lut [17] = '{2048, 2550, 2994, 3349, 3608, 3785, 3902, 3976, 4022,
                        4051, 4069, 4079, 4086, 4090, 4092, 4094, 4095};

  y_elem_t y_expected [$];   // expected output elements, oldest first
  y_elem_t y_step [$];       // elements produced by the last predicted step

  int  errors = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  function automatic longint round_q12(longint acc);
    longint v;
    v = acc + 2048;
    if (v >= 0) return v / 4096;
    return -((-v + 4095) / 4096);
  endfunction

  function automatic int clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // table sigmoid with truncated linear interpolation, odd around 0.5
  function automatic int sigmoid_q12(int x);
    longint a;
    int i, f, s;
    a = (x < 0) ? -longint'(x) : longint'(x);
    if (a > 32767) a = 32767;
    i = int'(a / 2048);
    f = int'(a % 2048);
    s = sig_lut[i] + ((sig_lut[i+1] - sig_lut[i]) * f) / 2048;
    return (x < 0) ? 4096 - s : s;
  endfunction

  function automatic int tanh_q12(int x);
    return 2 * sigmoid_q12(clip16(2 * longint'(x))) - 4096;
  endfunction

  // store a weight word; anything outside its matrix is dropped
  function automatic void store_weight(int m, int r, int c, int v);
    if (m < 4) begin
      if (r < FDIM && c < HDIM) w_x[(m*FDIM + r)*HDIM + c] = v;
    end else if (m < 8) begin
      if (r < HDIM && c < HDIM) w_h[((m-4)*HDIM + r)*HDIM + c] = v;
    end else if (m < 11) begin
      if (r < HDIM && c < HDIM) w_peep[((m-8)*HDIM + r)*HDIM + c] = v;
    end else if (m < 15) begin
      if (r == 0 && c < HDIM) b_gate[(m-11)*HDIM + c] = v;
    end else if (m == M_OUT_W) begin
      if (r < HDIM && c < ODIM) w_y[r*ODIM + c] = v;
    end else if (m == M_OUT_B) begin
      if (r == 0 && c < ODIM) b_y[c] = v;
    end
  endfunction

  // one accepted transaction; fills y_step when a time step completes
  function automatic void lstm_predict(lstm_txn_t t);
    int xv [FDIM];
    int gv [4][HDIM];
    longint acc;
    y_elem_t e;
    y_step.delete();
    if (t.op == OP_WEIGHT) begin
      store_weight(int'(t.msel), int'(t.row), int'(t.col), int'(t.wval));
      return;
    end
    if (t.sos) begin
      foreach (h_vec[j]) h_vec[j] = 0;
      foreach (c_vec[j]) c_vec[j] = 0;
    end
    if (x_cnt < FDIM) begin
      x_buf[x_cnt] = int'(t.fval);
      x_cnt++;
    end
    if (!t.eov) return;
    // short vector: missing elements count as zero
    for (int k = 0; k < FDIM; k++) xv[k] = (k < x_cnt) ? x_buf[k] : 0;
    x_cnt = 0;
    for (int g = 0; g < 4; g++) begin
      for (int j = 0; j < HDIM; j++) begin
        acc = longint'(b_gate[g*HDIM + j]) * 4096;
        for (int k = 0; k < FDIM; k++)
          acc += longint'(xv[k]) * w_x[(g*FDIM + k)*HDIM + j];
        for (int k = 0; k < HDIM; k++)
          acc += longint'(h_vec[k]) * w_h[(g*HDIM + k)*HDIM + j];
        if (peep_on && g < 3)
          for (int k = 0; k < HDIM; k++)
            acc += longint'(c_vec[k]) * w_peep[(g*HDIM + k)*HDIM + j];
        gv[g][j] = (gate_t'(g) == G_CELL) ? tanh_q12(clip16(round_q12(acc)))
                                           : sigmoid_q12(clip16(round_q12(acc)));
      end
    end
    for (int j = 0; j < HDIM; j++) begin
      acc = longint'(gv[G_CELL][j]) * gv[G_IN][j] + longint'(c_vec[j]) * gv[G_FORGET][j];
      c_vec[j] = clip16(round_q12(acc));
      h_vec[j] = clip16(round_q12(longint'(tanh_q12(c_vec[j])) * gv[G_OUT][j]));
    end
    for (int j = 0; j < ODIM; j++) begin
      acc = longint'(b_y[j]) * 4096;
      for (int k = 0; k < HDIM; k++) acc += longint'(h_vec[k]) * w_y[k*ODIM + j];
      e.idx = 6'(j);
      e.val = 16'(sigmoid_q12(clip16(round_q12(acc))));
      e.last = (j == ODIM - 1);
      y_step = {y_step, e};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one transaction per call, random idle gaps before it
  // ---------------------------------------------------------------------------
  task automatic send_txn(input lstm_txn_t t);
    y_elem_t e;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= t.op;
    in_matrix_select <= t.msel;
    in_weight_row <= t.row;
    in_weight_col <= t.col;
    in_weight_value <= t.wval;
    in_feature_value <= t.fval;
    in_end_of_vector <= t.eov;
    in_start_sequence <= t.sos;
    do @(posedge clk); while (in_stall);
    // transaction accepted at this edge
    lstm_predict(t);
    foreach (y_step[j]) begin
      e = y_step[j];
      if (t.has_y) e.val = t.y[j];   // typed-in value replaces the predicted one
      y_expected = {y_expected, e};
    end
  endtask

  function automatic lstm_txn_t weight_txn(int m, int r, int c, int v);
    lstm_txn_t t;
    t = '{op: OP_WEIGHT, default: '0};
    t.msel = 5'(m);
    t.row = 6'(r);
    t.col = 6'(c);
    t.wval = 16'(v);
    return t;
  endfunction

  function automatic lstm_txn_t feature_txn(int v, bit eov, bit sos);
    lstm_txn_t t;
    t = '{op: OP_FEATURE, default: '0};
    t.fval = 16'(v);
    t.eov = eov;
    t.sos = sos;
    return t;
  endfunction

  function automatic lstm_txn_t with_y(lstm_txn_t t, int y0, int y1, int y2, int y3);
    t.has_y = 1'b1;
    t.y = {16'(y3), 16'(y2), 16'(y1), 16'(y0)};
    return t;
  endfunction

  // mostly modest values so the gates stay off the rails, sometimes full range
  function automatic int pick_value();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  // write every in-range word of matrices m_lo to m_hi
  task automatic load_weights(input int m_lo, input int m_hi, input bit zeros);
    int rows, cols;
    for (int m = m_lo; m <= m_hi; m++) begin
      rows = (m < 4) ? FDIM : (m < 11) ? HDIM : (m < 15) ? 1 : (m == M_OUT_W) ? HDIM : 1;
      cols = (m < 15) ? HDIM : ODIM;
      for (int r = 0; r < rows; r++)
        for (int c = 0; c < cols; c++)
          send_txn(weight_txn(m, r, c, zeros ? 0 : pick_value()));
    end
  endtask

  // let every expected element arrive, then a quiet gap before any register write
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (y_expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_peephole(input bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    peep_on = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random traffic: mostly whole vectors, with noise writes and broken vectors
  task automatic random_traffic(input int n_items);
    int sent, len, kind;
    lstm_txn_t t;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // arbitrary write, often out of range, stray control bits set
        t = weight_txn($urandom_range(0, 31), $urandom_range(0, 63),
                       $urandom_range(0, 63), int'($urandom_range(0, 65535)) - 32768);
        t.eov = 1'($urandom_range(0, 1));
        t.sos = 1'($urandom_range(0, 1));
        send_txn(t);
      end else if (kind == 1) begin
        t = weight_txn($urandom_range(0, 14), $urandom_range(0, 7), $urandom_range(0, 15),
                       pick_value());
        if (t.msel >= 11) t.row = '0;
        send_txn(t);
        sent++;
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          t = feature_txn(pick_value() * 4, k == len - 1, k == 0 && $urandom_range(0, 3) == 0);
          if (k == len - 1 && $urandom_range(0, 9) == 0) t.eov = 1'b0;  // vector left open
          send_txn(t);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, compare each transaction with the oldest one queued
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    y_elem_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (y_expected.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output: index %0d value %0d last %0b",
                   out_output_index, out_output_value, out_last);
      end else begin
        e = y_expected.pop_front();
        if (out_output_index !== e.idx || out_output_value !== e.val || out_last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("output mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
                     e.idx, e.val, e.last, out_output_index, out_output_value, out_last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed part: all-zero weights give 0.5 everywhere; output bias at the
  // rails then gives the saturated sigmoid ends
  // ---------------------------------------------------------------------------
  lstm_txn_t directed [$];

  initial begin
    lstm_txn_t t;
    foreach (h_vec[j]) h_vec[j] = 0;
    foreach (c_vec[j]) c_vec[j] = 0;
    x_cnt = 0;
    peep_on = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_peephole(1'b0);
    // every word written once, so no step reads an unwritten entry
    load_weights(0, M_OUT_B, 1'b1);

    // extremes of the feature field, start of sequence
    directed = {directed, feature_txn(32767, 1'b0, 1'b1)};
    directed = {directed, with_y(feature_txn(-32768, 1'b1, 1'b0), 2048, 2048, 2048, 2048)};
    // output bias at both rails; a weight transaction ignores its control bits
    t = weight_txn(M_OUT_B, 0, 0, 32767);
    t.eov = 1'b1;
    t.sos = 1'b1;
    directed = {directed, t};
    directed = {directed, weight_txn(M_OUT_B, 0, 1, -32768)};
    directed = {directed, weight_txn(M_OUT_B, 0, 2, 32767)};
    directed = {directed, weight_txn(M_OUT_B, 0, 3, -32768)};
    directed = {directed, with_y(feature_txn(0, 1'b1, 1'b0), 4094, 2, 4094, 2)};
    // out-of-range writes are dropped
    directed = {directed, weight_txn(17, 0, 0, 32767)};
    directed = {directed, weight_txn(31, 63, 63, -32768)};
    directed = {directed, weight_txn(0, 8, 0, 32767)};
    directed = {directed, weight_txn(M_OUT_B, 1, 0, -32768)};
    directed = {directed, weight_txn(M_OUT_W, 0, 4, 32767)};
    directed = {directed, with_y(feature_txn(4096, 1'b1, 1'b0), 4094, 2, 4094, 2)};
    // buffer overflow: ten elements into an eight-deep buffer
    for (int k = 0; k < 10; k++)
      directed = {directed, feature_txn(k * 1000 - 5000, k == 9, 1'b0)};
    directed[directed.size()-1] = with_y(directed[directed.size()-1], 4094, 2, 4094, 2);
    foreach (directed[i]) send_txn(directed[i]);
    drain();

    // random biases and output weights, then one short vector checked by the predictor
    load_weights(M_GATE_B, M_OUT_B, 1'b0);
    send_txn(feature_txn(3000, 1'b0, 1'b1));
    send_txn(feature_txn(-2000, 1'b1, 1'b0));
    drain();

    // phase 1: no idling, peephole off
    random_traffic(70);
    drain();
    // phase 2: sender idles, peephole on; sender waits for every result first
    write_peephole(1'b1);
    send_idle_pct = 63;
    random_traffic(70);
    drain();
    // phase 3: receiver stalls, peephole off
    write_peephole(1'b0);
    send_idle_pct = 0;
    recv_stall_pct = 63;
    random_traffic(70);
    drain();
    // phase 4: both idle now and then, peephole on
    write_peephole(1'b1);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    random_traffic(70);
    drain();

    // watch for stray outputs after the last step
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && y_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
